[sv/segmented_stack_delete_at_assert.svh]
// ----------------------------------------------------------------------------
// segmented_stack_delete_at_assert.svh
// assertion macros used by segmented_stack_delete_at
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_STACK_DELETE_AT_ASSERT_SVH
`define SEGMENTED_STACK_DELETE_AT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SSD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/ssd_pkg.sv]
// ----------------------------------------------------------------------------
// ssd_pkg
// sizes, codes and types of the segmented stack with delete-at
// ----------------------------------------------------------------------------
package ssd_pkg;

	localparam int STORE_DEPTH = 1024;
	localparam int DATA_WIDTH  = 32;

	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
	localparam int STEP_W = $clog2(ADDR_W + 1);

	localparam int CAP_W       = 11;
	localparam int VALUE_W     = 32;
	localparam int SEG_W       = 10;
	localparam int CMD_W       = 2;
	localparam int STAT_W      = 2;
	localparam int CNT_OUT_W   = 11;
	localparam int PROD_W      = 2 * CAP_W;
	localparam int S_TDATA_W   = 48;
	localparam int M_TDATA_W   = 56;
	localparam int M_PAD_W     = M_TDATA_W - (VALUE_W + 1 + 2 * CNT_OUT_W);
	localparam int S_PAD_W     = S_TDATA_W - (VALUE_W + SEG_W);

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(20);

	localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_POP_AT = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic              dn;
		logic              up;
		logic [ADDR_W-1:0] thr;
	} cell_ctl_t;

endpackage

[sv/ssd_cell.sv]
// ----------------------------------------------------------------------------
// ssd_cell
// one storage cell of the row; cell 0 holds the top of the stack
// ----------------------------------------------------------------------------
module ssd_cell (
	input  logic                           clk,
	input  logic [ssd_pkg::ADDR_W-1:0]     idx,
	input  ssd_pkg::cell_ctl_t             ctl,
	input  logic [ssd_pkg::DATA_WIDTH-1:0] above,
	input  logic [ssd_pkg::DATA_WIDTH-1:0] below,
	output logic [ssd_pkg::DATA_WIDTH-1:0] q
);
	import ssd_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.dn) begin
			data_q <= above;
		end else if (ctl.up && (idx >= ctl.thr)) begin
			data_q <= below;
		end
	end

	assign q = data_q;

endmodule

[sv/ssd_segcnt.sv]
// ----------------------------------------------------------------------------
// ssd_segcnt
// restoring divider: sub-stack count and fill of the last one after a
// capacity change, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ssd_segcnt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ssd_pkg::CNT_W-1:0] total,
	input  logic [ssd_pkg::CAP_W-1:0] cap,
	output logic                      busy,
	output logic                      done,
	output logic [ssd_pkg::CNT_W-1:0] segs,
	output logic [ssd_pkg::CAP_W-1:0] rem
);
	import ssd_pkg::*;

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [ADDR_W-1:0] n_q;
	logic [ADDR_W-1:0] quo_q;
	logic [CAP_W-1:0]  r_q;
	logic [CAP_W-1:0]  c_q;
	logic              zero_q;
	logic [CAP_W:0]    trial;
	logic              fits;

	assign trial = {r_q, n_q[ADDR_W-1]};
	assign fits  = trial >= {1'b0, c_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= STEP_W'(ADDR_W);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= ADDR_W'(total - 1'b1);
			zero_q <= (total == '0);
			c_q    <= cap;
			r_q    <= '0;
			quo_q  <= '0;
		end else if (run_q) begin
			n_q   <= n_q << 1;
			quo_q <= {quo_q[ADDR_W-2:0], fits};
			r_q   <= fits ? CAP_W'(trial - {1'b0, c_q}) : CAP_W'(trial);
		end
	end

	assign busy = run_q;
	assign done = done_q;
	assign segs = zero_q ? CNT_W'(1) : CNT_W'(quo_q) + 1'b1;
	assign rem  = zero_q ? '0 : r_q + 1'b1;

endmodule

[sv/segmented_stack_delete_at.sv]
// ----------------------------------------------------------------------------
// segmented_stack_delete_at
// stack split into sub-stacks of a set capacity, with pop from a named
// sub-stack; elements live in a row of cells, top in cell 0
// ----------------------------------------------------------------------------
// channel   dir  tdata (low bit up)                       tuser
// s_*       in   push_value, segment_index                command
// m_*       out  top_value, is_empty, segment_count,      status
//                item_count
// cfg_*     in   segment_capacity on cfg_we
//
// push, pop and rejected items are done once accepted; the next item can follow at once unless the output is held
// pop-at first forms the sub-stack end product, then does one shift along the row
// a capacity write starts a recount in the divider; s_tready is low until it is done
// no clearing after reset; cells only read below the item count
// the output register takes a new item while the last is being drained
// ----------------------------------------------------------------------------
`include "segmented_stack_delete_at_assert.svh"

module segmented_stack_delete_at (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ssd_pkg::S_TDATA_W-1:0] s_tdata,   // push_value, segment_index
	input  logic [ssd_pkg::CMD_W-1:0]     s_tuser,   // command
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ssd_pkg::M_TDATA_W-1:0] m_tdata,   // top_value, is_empty, seg count, item count
	output logic [ssd_pkg::STAT_W-1:0]    m_tuser,   // status
	input  logic                          cfg_we,
	input  logic [ssd_pkg::CAP_W-1:0]     cfg_data
);
	import ssd_pkg::*;

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_DELETE = 1'b1;

	logic                  state_q;
	logic [CNT_W-1:0]      total_q;
	logic [CNT_W-1:0]      segs_q;
	logic [CAP_W-1:0]      rem_q;
	logic [CAP_W-1:0]      cap_q;
	logic                  recalc_q;
	logic [PROD_W-1:0]     end_q;
	logic                  m_tvalid_q;
	logic [M_TDATA_W-1:0]  m_tdata_q;
	logic [STAT_W-1:0]     m_tuser_q;

	logic [DATA_WIDTH-1:0] cell_q [STORE_DEPTH];
	cell_ctl_t             ctl;

	logic [CAP_W-1:0]      cap_eff;
	logic                  div_busy;
	logic                  div_done;
	logic [CNT_W-1:0]      div_segs;
	logic [CAP_W-1:0]      div_rem;

	logic                  acc;
	logic [CMD_W-1:0]      cmd;
	logic [VALUE_W-1:0]    push_value;
	logic [SEG_W-1:0]      seg_index;
	logic [PROD_W-1:0]     total_wide;
	logic [PROD_W-1:0]     gap;
	logic [ADDR_W-1:0]     del_thr;

	logic [CNT_W-1:0]      total_n;
	logic [CNT_W-1:0]      segs_n;
	logic [CAP_W-1:0]      rem_n;
	logic [DATA_WIDTH-1:0] top_n;
	logic [STAT_W-1:0]     stat_n;
	logic                  load_out;
	logic                  go_del;
	logic [VALUE_W-1:0]    top_out;

	assign cap_eff    = (cap_q == '0) ? CAP_W'(1) : cap_q;
	assign acc        = s_tvalid && s_tready;
	assign cmd        = s_tuser;
	assign push_value = s_tdata[VALUE_W-1:0];
	assign seg_index  = s_tdata[VALUE_W+SEG_W-1:VALUE_W];
	assign total_wide = PROD_W'(total_q);
	assign gap        = total_wide - end_q;
	assign del_thr    = (total_wide > end_q) ? ADDR_W'(gap) : '0;

	assign s_tready = (state_q == ST_IDLE) && !recalc_q && !div_busy && !div_done &&
		(!m_tvalid_q || m_tready);

	always_comb begin
		ctl      = '0;
		total_n  = total_q;
		segs_n   = segs_q;
		rem_n    = rem_q;
		top_n    = cell_q[0];
		stat_n   = ST_OK;
		load_out = 1'b0;
		go_del   = 1'b0;
		if (acc) begin
			case (cmd)
				CMD_PUSH: begin
					load_out = 1'b1;
					if (total_q >= CNT_W'(STORE_DEPTH)) begin
						stat_n = ST_FULL;
					end else begin
						ctl.dn  = 1'b1;
						total_n = total_q + 1'b1;
						top_n   = DATA_WIDTH'(push_value);
						if (rem_q >= cap_eff) begin
							segs_n = segs_q + 1'b1;
							rem_n  = CAP_W'(1);
						end else begin
							rem_n = rem_q + 1'b1;
						end
					end
				end
				CMD_POP: begin
					load_out = 1'b1;
					if (total_q == '0) begin
						stat_n = ST_EMPTY;
					end else begin
						ctl.up  = 1'b1;
						total_n = total_q - 1'b1;
						top_n   = cell_q[1];
						if (rem_q == CAP_W'(1) && segs_q > CNT_W'(1)) begin
							segs_n = segs_q - 1'b1;
							rem_n  = cap_eff;
						end else begin
							rem_n = rem_q - 1'b1;
						end
					end
				end
				CMD_POP_AT: begin
					if (CNT_W'(seg_index) >= segs_q) begin
						stat_n   = ST_RANGE;
						load_out = 1'b1;
					end else if (total_q == '0) begin
						stat_n   = ST_EMPTY;
						load_out = 1'b1;
					end else begin
						go_del = 1'b1;
					end
				end
				default: begin
					load_out = 1'b1;
				end
			endcase
		end else if (state_q == ST_DELETE) begin
			load_out = 1'b1;
			ctl.up   = 1'b1;
			ctl.thr  = del_thr;
			total_n  = total_q - 1'b1;
			top_n    = (del_thr == '0) ? cell_q[1] : cell_q[0];
			if (rem_q == CAP_W'(1) && segs_q > CNT_W'(1)) begin
				segs_n = segs_q - 1'b1;
				rem_n  = cap_eff;
			end else begin
				rem_n = rem_q - 1'b1;
			end
		end
	end

	assign top_out = (total_n == '0) ? '0 : VALUE_W'(top_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			total_q    <= '0;
			segs_q     <= CNT_W'(1);
			rem_q      <= '0;
			cap_q      <= CAP_RESET;
			recalc_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			total_q <= total_n;
			if (div_done) begin
				segs_q <= div_segs;
				rem_q  <= div_rem;
			end else begin
				segs_q <= segs_n;
				rem_q  <= rem_n;
			end
			if (cfg_we) begin
				cap_q    <= cfg_data;
				recalc_q <= 1'b1;
			end else begin
				recalc_q <= 1'b0;
			end
			state_q <= go_del ? ST_DELETE : ST_IDLE;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_del) begin
			end_q <= (PROD_W'(seg_index) + 1'b1) * PROD_W'(cap_eff);
		end
		if (load_out) begin
			m_tuser_q <= stat_n;
			m_tdata_q <= {{M_PAD_W{1'b0}}, CNT_OUT_W'(total_n), CNT_OUT_W'(segs_n),
				(total_n == '0), top_out};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	ssd_segcnt u_segcnt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (recalc_q),
		.total  (total_q),
		.cap    (cap_eff),
		.busy   (div_busy),
		.done   (div_done),
		.segs   (div_segs),
		.rem    (div_rem)
	);

	for (genvar j = 0; j < STORE_DEPTH; j++) begin : g_cell
		logic [DATA_WIDTH-1:0] above;
		logic [DATA_WIDTH-1:0] below;
		if (j == 0) begin : g_first
			assign above = DATA_WIDTH'(push_value);
		end else begin : g_mid
			assign above = cell_q[j-1];
		end
		if (j == STORE_DEPTH - 1) begin : g_last
			assign below = cell_q[j];
		end else begin : g_inner
			assign below = cell_q[j+1];
		end
		ssd_cell u_cell (
			.clk   (clk),
			.idx   (ADDR_W'(j)),
			.ctl   (ctl),
			.above (above),
			.below (below),
			.q     (cell_q[j])
		);
	end

	`SSD_ASSERT_NEXT(a_delete_gives_result, state_q == ST_DELETE, m_tvalid, "pop-at gave no result")
	`SSD_ASSERT_NOW(a_no_take_when_blocked, s_tready, !m_tvalid_q || m_tready, "item taken while output blocked")
	`SSD_ASSERT_NOW(a_count_bound, 1'b1, total_q <= CNT_W'(STORE_DEPTH), "item count past store depth")
	`SSD_ASSERT_NOW(a_fill_bound, !recalc_q && !div_busy && !div_done, rem_q <= cap_eff, "last sub-stack fill past capacity")

endmodule

[bench/segmented_stack_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_stack_monitor
// watches the command, result and capacity channels, keeps its own copy of
// the flat element store, predicts each result and compares it field by field
// ----------------------------------------------------------------------------
module segmented_stack_monitor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [ssd_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [ssd_pkg::CMD_W-1:0]     s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [ssd_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic [ssd_pkg::STAT_W-1:0]    m_tuser,
	input  logic                          cfg_we,
	input  logic [ssd_pkg::CAP_W-1:0]     cfg_data,
	output int                            fail_count,
	output int                            pending,
	output int                            stored_count,
	output int                            stored_segments
);
	import ssd_pkg::*;

	typedef struct packed {
		logic [STAT_W-1:0]    status;
		logic [VALUE_W-1:0]   top_value;
		logic                 is_empty;
		logic [CNT_OUT_W-1:0] segment_count;
		logic [CNT_OUT_W-1:0] item_count;
	} stack_report_t;

	logic [VALUE_W-1:0] element_copy [STORE_DEPTH];
	int                 depth_now;
	logic [CAP_W-1:0]   capacity_now;
	stack_report_t      awaited_reports [$];
	stack_report_t      fresh_report;
	stack_report_t      oldest_report;

	initial fail_count = 0;

	function automatic int segments_for(input int n, input logic [CAP_W-1:0] cap);
		int c;
		int s;
		c = (cap == '0) ? 1 : int'(cap);
		s = (n + c - 1) / c;
		return (s == 0) ? 1 : s;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] seen,
			input logic [63:0] wanted);
		fail_count++;
		if (fail_count <= 40)
			$display("mismatch at %0t: %s seen %0h wanted %0h", $time, what, seen, wanted);
	endtask

	task automatic compare_field(input string what, input logic [63:0] seen,
			input logic [63:0] wanted);
		if (seen !== wanted)
			report_mismatch(what, seen, wanted);
	endtask

	task automatic apply_stack_command(input logic [CMD_W-1:0] cmd,
			input logic [VALUE_W-1:0] value, input logic [SEG_W-1:0] index,
			output stack_report_t rep);
		int     c;
		int     pos;
		int     i;
		longint seg_end;
		c = (capacity_now == '0) ? 1 : int'(capacity_now);
		rep.status = ST_OK;
		case (cmd)
			CMD_PUSH: begin
				if (depth_now >= STORE_DEPTH) begin
					rep.status = ST_FULL;
				end else begin
					element_copy[depth_now] = value;
					depth_now++;
				end
			end
			CMD_POP: begin
				if (depth_now == 0)
					rep.status = ST_EMPTY;
				else
					depth_now--;
			end
			CMD_POP_AT: begin
				if (int'(index) >= segments_for(depth_now, capacity_now)) begin
					rep.status = ST_RANGE;
				end else if (depth_now == 0) begin
					rep.status = ST_EMPTY;
				end else begin
					// removed slot is the top of the named sub-stack, the rest rolls down
					seg_end = (longint'(index) + 1) * c;
					pos = (seg_end < depth_now) ? int'(seg_end) - 1 : depth_now - 1;
					for (i = pos; i + 1 < depth_now; i++)
						element_copy[i] = element_copy[i + 1];
					depth_now--;
				end
			end
			default: ;
		endcase
		rep.top_value     = (depth_now == 0) ? '0 : element_copy[depth_now - 1];
		rep.is_empty      = (depth_now == 0);
		rep.segment_count = CNT_OUT_W'(segments_for(depth_now, capacity_now));
		rep.item_count    = CNT_OUT_W'(depth_now);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_now = 0;
			capacity_now = CAP_RESET;
			awaited_reports.delete();
		end else begin
			if (cfg_we)
				capacity_now = cfg_data;
			if (m_tvalid && m_tready) begin
				if (awaited_reports.size() == 0) begin
					report_mismatch("result with no item waiting", m_tdata, '0);
				end else begin
					oldest_report = awaited_reports.pop_front();
					compare_field("status", m_tuser, oldest_report.status);
					compare_field("top_value", m_tdata[31:0], oldest_report.top_value);
					compare_field("is_empty", m_tdata[32], oldest_report.is_empty);
					compare_field("segment_count", m_tdata[43:33],
						oldest_report.segment_count);
					compare_field("item_count", m_tdata[54:44], oldest_report.item_count);
				end
			end
			if (s_tvalid && s_tready) begin
				apply_stack_command(s_tuser, s_tdata[VALUE_W-1:0],
					s_tdata[VALUE_W+SEG_W-1:VALUE_W], fresh_report);
				awaited_reports.insert(awaited_reports.size(), fresh_report);
			end
		end
		pending = awaited_reports.size();
		stored_count = depth_now;
		stored_segments = segments_for(depth_now, capacity_now);
	end

endmodule

[bench/tb_segmented_stack_delete_at.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segmented_stack_delete_at
// drives push, pop and pop-at commands with random gaps and back-pressure,
// rewrites the sub-stack capacity between phases, then drains the store
// ----------------------------------------------------------------------------
module tb_segmented_stack_delete_at;
	import ssd_pkg::*;

	localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 60;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [CMD_W-1:0]     s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]    m_tuser;
	logic                 cfg_we;
	logic [CAP_W-1:0]     cfg_data;

	int fail_count;
	int pending;
	int stored_count;
	int stored_segments;
	int idle_cycles = 0;
	int s_run_left = 0;
	int m_run_left = 0;
	bit s_no_wait;
	bit m_no_wait;
	int stall;
	int phase;
	int left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	segmented_stack_delete_at DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	segmented_stack_monitor monitor (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.cfg_we          (cfg_we),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.pending         (pending),
		.stored_count    (stored_count),
		.stored_segments (stored_segments)
	);

	// runs of items either all without gaps or all with random gaps
	function automatic int draw_wait(inout int run_left, inout bit no_wait);
		if (run_left == 0) begin
			no_wait = ($urandom_range(0, 3) == 0);
			run_left = $urandom_range(8, 40);
		end
		run_left--;
		return no_wait ? 0 : $urandom_range(0, 16);
	endfunction

	// called and returns at a falling edge
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
			input logic [SEG_W-1:0] index);
		int gap;
		gap = draw_wait(s_run_left, s_no_wait);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{S_PAD_W{1'b0}}, index, value};
		s_tuser <= cmd;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		settle();
		cfg_we <= 1'b1;
		cfg_data <= cap;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_item();
		int               r;
		logic [CMD_W-1:0] cmd;
		logic [SEG_W-1:0] index;
		r = $urandom_range(0, 99);
		index = SEG_W'($urandom);
		if (r < 52) begin
			cmd = CMD_PUSH;
		end else if (r < 70) begin
			cmd = CMD_POP;
		end else if (r < 95) begin
			cmd = CMD_POP_AT;
			if ($urandom_range(0, 7) != 0)
				index = SEG_W'($urandom_range(0, stored_segments));
		end else begin
			cmd = CMD_NOP;
		end
		send_item(cmd, $urandom, index);
	endtask

	function automatic logic [CAP_W-1:0] phase_capacity(input int p);
		case (p)
			0: return CAP_W'(1);
			1: return CAP_W'(1024);
			2: return CAP_W'(7);
			3: return CAP_W'(2047);
			4: return CAP_W'(3);
			5: return CAP_W'(0);
			default: return CAP_W'($urandom_range(2, 40));
		endcase
	endfunction

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			stall = draw_wait(m_run_left, m_no_wait);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_PUSH;
		cfg_we = 1'b0;
		cfg_data = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty store and out-of-range cases at the reset capacity
		send_item(CMD_POP, $urandom, '0);
		send_item(CMD_POP_AT, $urandom, SEG_W'(0));
		send_item(CMD_POP_AT, $urandom, SEG_W'(1));
		send_item(CMD_POP_AT, $urandom, '1);
		send_item(CMD_NOP, $urandom, SEG_W'($urandom));
		send_item(CMD_PUSH, 32'h8000_0000, '0);
		send_item(CMD_PUSH, 32'h7fff_ffff, '1);
		send_item(CMD_PUSH, 32'hffff_ffff, '0);
		send_item(CMD_PUSH, 32'h0000_0000, '1);
		send_item(CMD_POP_AT, '1, SEG_W'(0));
		send_item(CMD_POP, '1, '1);
		send_item(CMD_PUSH, 32'h5a5a_a5a5, '1);
		send_item(CMD_NOP, '1, '1);

		// zero capacity re-splits the stored elements one per sub-stack
		write_capacity(CAP_W'(0));
		send_item(CMD_PUSH, 32'h0000_0001, '0);
		send_item(CMD_PUSH, 32'h0000_0002, '0);
		send_item(CMD_POP_AT, $urandom, SEG_W'(1));
		send_item(CMD_POP_AT, $urandom, SEG_W'(0));
		send_item(CMD_POP_AT, $urandom, SEG_W'(4));
		send_item(CMD_POP_AT, $urandom, SEG_W'(3));

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			write_capacity(phase_capacity(phase));
			repeat (ITEMS_PER_PHASE) random_item();
		end

		// one element per sub-stack, pops at both ends of the row
		write_capacity(CAP_W'(1));
		send_item(CMD_POP_AT, $urandom, SEG_W'(1023));
		send_item(CMD_PUSH, $urandom, SEG_W'($urandom));
		send_item(CMD_POP_AT, $urandom, SEG_W'(0));
		send_item(CMD_PUSH, $urandom, SEG_W'($urandom));

		write_capacity(CAP_W'(1024));
		send_item(CMD_POP_AT, $urandom, SEG_W'(1));
		send_item(CMD_POP_AT, $urandom, SEG_W'(0));

		write_capacity(CAP_W'(2));
		left = stored_count;
		repeat (left) begin
			if ($urandom_range(0, 1) == 0)
				send_item(CMD_POP, $urandom, SEG_W'($urandom));
			else
				send_item(CMD_POP_AT, $urandom,
					SEG_W'($urandom_range(0, stored_segments - 1)));
		end
		send_item(CMD_POP, $urandom, SEG_W'($urandom));
		send_item(CMD_POP_AT, $urandom, SEG_W'(0));
		send_item(CMD_POP_AT, $urandom, SEG_W'(1));

		settle();
		repeat (20) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
+incdir+sv
sv/ssd_pkg.sv
sv/ssd_cell.sv
sv/ssd_segcnt.sv
sv/segmented_stack_delete_at.sv
bench/segmented_stack_monitor.sv
bench/tb_segmented_stack_delete_at.sv
